// ----- rtl/core/seud_pkg.sv -----
`timescale 1ns / 1ps

package seud_pkg;

  // Decoder mode: normal text, after a backslash, or waiting for one of the
  // four hex digits of a \u escape.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_e;

  // Characters that the decoder looks for.
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [7:0] CharB         = 8'h62;
  localparam logic [7:0] CharF         = 8'h66;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharUpperA    = 8'h41;
  localparam logic [7:0] CharUpperF    = 8'h46;
  localparam logic [7:0] CharLowerA    = 8'h61;
  localparam logic [7:0] CharLowerF    = 8'h66;
  localparam logic [7:0] CharZero      = 8'h30;

  // Control bytes for the lettered escapes.
  localparam logic [7:0] CtrlBackspace = 8'h08;
  localparam logic [7:0] CtrlFormFeed  = 8'h0C;
  localparam logic [7:0] CtrlNewline   = 8'h0A;
  localparam logic [7:0] CtrlReturn    = 8'h0D;
  localparam logic [7:0] CtrlTab       = 8'h09;

  // UTF-8 encoding limits and marker bits.
  localparam logic [15:0] Utf8OneByteLimit = 16'd128;
  localparam logic [15:0] Utf8TwoByteLimit = 16'd2048;
  localparam logic [2:0]  Utf8Lead2        = 3'b110;
  localparam logic [3:0]  Utf8Lead3        = 4'b1110;
  localparam logic [1:0]  Utf8Cont         = 2'b10;

  // One job handed from the front to the back: up to three bytes to emit,
  // in order from index 0. A byte count of zero is an end-only marker.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            str_end;
  } job_t;

endpackage

// ----- rtl/core/string_escape_utf8_decoder.sv -----
`timescale 1ns / 1ps
// Channel   Dir  tdata         tuser                  tlast
// s_axis    in   in_byte[7:0]  -                      string_last
// m_axis    out  out_byte[7:0] has_byte[0] run_last[1] string_end
//
// Input bytes are taken while the queue has room; one result leaves per cycle
// while m_axis_tready is high, and a byte's first result passes through the job
// queue and then the output register. A \u escape that ends in a 2- or 3-byte
// UTF-8 sequence keeps the emitter busy until all its bytes have left; with a
// steady input stream and the default two-entry job queue, the input then stalls.
// Input is stalled only when the queue is full, which also follows output stalls.
// Reset clears the decoder to normal mode and empties queue and output.

module string_escape_utf8_decoder #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] has_byte, [1] run_last
  output logic       m_axis_tlast
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  seud_pkg::job_t push_job;
  seud_pkg::job_t head_job;
  logic           has_byte;
  logic           run_last;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Front: decode escapes into output jobs.
  seud_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (s_axis_tdata),
    .string_last_i (s_axis_tlast),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Job queue between the two halves.
  seud_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job),
    .full_o  (q_full)
  );

  // Back: emit the job bytes one transfer at a time.
  seud_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .has_byte_o   (has_byte),
    .run_last_o   (run_last),
    .string_end_o (m_axis_tlast)
  );

  assign m_axis_tuser = {run_last, has_byte};

endmodule

// ----- rtl/core/seud_front.sv -----
`timescale 1ns / 1ps

module seud_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              string_last_i,
  output logic              push_o,
  output seud_pkg::job_t    job_o
);

  seud_pkg::mode_e mode_q, mode_d;
  logic [15:0]     accum_q, accum_d;
  logic [15:0]     hex_val;
  logic [15:0]     accum_next;
  seud_pkg::job_t  job;

  // Hex digit value; any non-hex byte counts as its signed value minus 48.
  always_comb begin
    if (in_byte_i inside {[seud_pkg::CharUpperA:seud_pkg::CharUpperF]}) begin
      hex_val = {8'h00, in_byte_i - seud_pkg::CharUpperA} + 16'd10;
    end else if (in_byte_i inside {[seud_pkg::CharLowerA:seud_pkg::CharLowerF]}) begin
      hex_val = {8'h00, in_byte_i - seud_pkg::CharLowerA} + 16'd10;
    end else begin
      hex_val = {{8{in_byte_i[7]}}, in_byte_i} - {8'h00, seud_pkg::CharZero};
    end
  end

  assign accum_next = {accum_q[11:0], 4'h0} + hex_val;

  // Classify the byte and build the job it causes.
  always_comb begin
    mode_d      = mode_q;
    accum_d     = accum_q;
    job.bytes   = '0;
    job.nbytes  = 2'd0;
    job.str_end = string_last_i;

    case (mode_q)
      seud_pkg::MODE_ESCAPE: begin
        mode_d     = seud_pkg::MODE_NORMAL;
        job.nbytes = 2'd1;
        case (in_byte_i)
          seud_pkg::CharU: begin
            mode_d     = seud_pkg::MODE_HEX0;
            accum_d    = '0;
            job.nbytes = 2'd0;
          end
          seud_pkg::CharB: job.bytes[0] = seud_pkg::CtrlBackspace;
          seud_pkg::CharF: job.bytes[0] = seud_pkg::CtrlFormFeed;
          seud_pkg::CharN: job.bytes[0] = seud_pkg::CtrlNewline;
          seud_pkg::CharR: job.bytes[0] = seud_pkg::CtrlReturn;
          seud_pkg::CharT: job.bytes[0] = seud_pkg::CtrlTab;
          default:         job.bytes[0] = in_byte_i;
        endcase
      end
      seud_pkg::MODE_HEX0: begin
        accum_d = accum_next;
        mode_d  = seud_pkg::MODE_HEX1;
      end
      seud_pkg::MODE_HEX1: begin
        accum_d = accum_next;
        mode_d  = seud_pkg::MODE_HEX2;
      end
      seud_pkg::MODE_HEX2: begin
        accum_d = accum_next;
        mode_d  = seud_pkg::MODE_HEX3;
      end
      seud_pkg::MODE_HEX3: begin
        // Last digit: emit the code point as UTF-8.
        accum_d = accum_next;
        mode_d  = seud_pkg::MODE_NORMAL;
        if (accum_next < seud_pkg::Utf8OneByteLimit) begin
          job.bytes[0] = {1'b0, accum_next[6:0]};
          job.nbytes   = 2'd1;
        end else if (accum_next < seud_pkg::Utf8TwoByteLimit) begin
          job.bytes[0] = {seud_pkg::Utf8Lead2, accum_next[10:6]};
          job.bytes[1] = {seud_pkg::Utf8Cont, accum_next[5:0]};
          job.nbytes   = 2'd2;
        end else begin
          job.bytes[0] = {seud_pkg::Utf8Lead3, accum_next[15:12]};
          job.bytes[1] = {seud_pkg::Utf8Cont, accum_next[11:6]};
          job.bytes[2] = {seud_pkg::Utf8Cont, accum_next[5:0]};
          job.nbytes   = 2'd3;
        end
      end
      default: begin
        mode_d = seud_pkg::MODE_NORMAL;
        if (in_byte_i == seud_pkg::CharBackslash) begin
          mode_d = seud_pkg::MODE_ESCAPE;
        end else begin
          job.bytes[0] = in_byte_i;
          job.nbytes   = 2'd1;
        end
      end
    endcase

    // The end of a string drops any open escape and starts fresh.
    if (string_last_i) begin
      mode_d  = seud_pkg::MODE_NORMAL;
      accum_d = '0;
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && ((job.nbytes != 2'd0) || string_last_i);

  // Decoder state advances on every accepted input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= seud_pkg::MODE_NORMAL;
      accum_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
    end
  end

endmodule

// ----- rtl/core/seud_queue.sv -----
`timescale 1ns / 1ps

module seud_queue #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  seud_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           valid_o,
  output seud_pkg::job_t job_o,
  output logic           full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  seud_pkg::job_t   entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign job_o   = entries_q[rd_ptr_q];

  // Job storage; written only at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/seud_back.sv -----
`timescale 1ns / 1ps

module seud_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  seud_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           has_byte_o,
  output logic           run_last_o,
  output logic           string_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       has_q, has_d;
  logic       run_last_q, run_last_d;
  logic       end_q, end_d;
  logic       load;
  logic       job_done;

  // The output register takes a new result whenever a job waits and the register is empty or drained.
  assign load = job_valid_i && (!valid_q || out_ready_i);

  // Pick the current byte of the head job.
  always_comb begin
    if (job_i.nbytes == 2'd0) begin
      byte_d   = '0;
      has_d    = 1'b0;
      job_done = 1'b1;
    end else begin
      byte_d   = job_i.bytes[idx_q];
      has_d    = 1'b1;
      job_done = (idx_q == job_i.nbytes - 2'd1);
    end
    run_last_d = job_done;
    end_d      = job_done && job_i.str_end;
    idx_d      = job_done ? 2'd0 : idx_q + 2'd1;
  end

  assign pop_o = load && job_done;

  // Byte index within the head job, and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_d;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= byte_d;
      has_q      <= has_d;
      run_last_q <= run_last_d;
      end_q      <= end_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign has_byte_o   = has_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = end_q;

endmodule
